[design/otrb_pkg.sv]
`timescale 1ns / 1ps

package otrb_pkg;

    localparam int RING_DEPTH = 64;
    localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    localparam int TICK_W  = 32;
    localparam int ID_W    = 31;
    localparam int CODE_W  = 3;
    localparam int LIMIT_W = 7;
    localparam int POS_W   = 6;
    localparam int TOTAL_W = 7;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [TICK_W-1:0]  tick;
        logic [ID_W-1:0]    group_id;
        logic [ID_W-1:0]    thread_id;
        logic               thread_flag;
        logic [CODE_W-1:0]  run_state;
        logic [CODE_W-1:0]  cpu_number;
        logic [CODE_W-1:0]  priority_level;
        logic [LIMIT_W-1:0] read_limit;
    } t_in;

    // One stored trace record, as held in the ring memory.
    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [ID_W-1:0]   group_id;
        logic [ID_W-1:0]   thread_id;
        logic              thread_flag;
        logic [CODE_W-1:0] run_state;
        logic [CODE_W-1:0] cpu_number;
        logic [CODE_W-1:0] priority_level;
    } t_rec;

    // Readout bookkeeping that travels alongside a memory read.
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [TOTAL_W-1:0] total_returned;
        logic               last;
        logic               empty_res;
    } t_meta;

    typedef struct packed {
        logic [TICK_W-1:0]  out_tick;
        logic [ID_W-1:0]    out_group_id;
        logic [ID_W-1:0]    out_thread_id;
        logic               out_thread_flag;
        logic [CODE_W-1:0]  out_run_state;
        logic [CODE_W-1:0]  out_cpu_number;
        logic [CODE_W-1:0]  out_priority_level;
        logic [POS_W-1:0]   position;
        logic [TOTAL_W-1:0] total_returned;
        logic               last;
        logic               empty_res;
    } t_res;

endpackage

[design/otrb_if.sv]
`timescale 1ns / 1ps

interface otrb_in_if;
    logic           valid;
    logic           ready;
    otrb_pkg::t_in  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface otrb_out_if;
    logic           valid;
    logic           ready;
    otrb_pkg::t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/overwriting_trace_ring_buffer_core.sv]
`timescale 1ns / 1ps

// Channel   Dir  Word                    Taken when
// i_in      in   command + trace record  i_in.valid && i_in.ready
// o_out     out  record + readout marks  o_out.valid && o_out.ready
//
// A store word is written to the ring memory on the edge that takes it.
// A read word is taken like a store word; its records then leave at one per cycle
// while o_out is ready, set by the single read port of the ring memory.
// An empty readout issues once and yields one word.
// Reset clears write position, fill count and control; memory contents are not cleared.
// Stalls on o_out hold back memory reads through a two-word output queue.
module overwriting_trace_ring_buffer_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    otrb_in_if.sink          i_in,
    otrb_out_if.source       o_out
);
    import otrb_pkg::*;

    // Ring memory: one record per entry, synchronous read.
    t_rec mem [RING_DEPTH];

    // Write side state.
    logic [ADDR_W-1:0]  r_wr_pos;
    logic [FILL_W-1:0]  r_fill;

    // Readout sequencer.
    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_addr;
    logic [TOTAL_W-1:0] r_idx;
    logic [TOTAL_W-1:0] r_n;
    logic               r_empty;

    // Read in flight: data lands in r_rdata in the cycle after issue.
    logic               r_pend;
    t_meta              r_pmeta;
    t_rec               r_rdata;

    // Two-word output queue, head in slot 0.
    t_res               r_q [2];
    t_res               n_q [2];
    logic [1:0]         r_qcnt, n_qcnt;

    logic               in_take;
    logic               do_store;
    logic               do_read;
    logic               pop;
    logic               issue;
    logic               issue_last;
    logic [TOTAL_W-1:0] fill_ext;
    logic [TOTAL_W-1:0] rd_n;
    logic [ADDR_W-1:0]  rd_start;
    t_meta              issue_meta;
    t_res               push_res;

    assign in_take  = i_in.valid && i_in.ready;
    assign do_store = in_take && (i_in.payload.command == CMD_STORE);
    assign do_read  = in_take && (i_in.payload.command == CMD_READ);
    assign pop      = (r_qcnt != 2'd0) && o_out.ready;

    // Records returned: the smaller of the fill count and the limit.
    assign fill_ext = TOTAL_W'(r_fill);
    assign rd_n     = (i_in.payload.read_limit < fill_ext) ? i_in.payload.read_limit
                                                           : fill_ext;
    // Oldest record sits at the write position once the ring has wrapped.
    assign rd_start = (r_fill == FILL_W'(RING_DEPTH)) ? r_wr_pos : '0;

    assign issue_last = (r_idx + TOTAL_W'(1)) == r_n;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (do_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (issue && (issue_last || r_empty)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: only issue while the queue has room for the
    // word already in flight plus this one, counting a word leaving now.
    always_comb begin
        i_in.ready = 1'b0;
        issue      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_READ: begin
                issue = (r_qcnt + 2'(r_pend)) <= (2'd1 + 2'(pop));
            end
            default: begin
                i_in.ready = 1'b0;
                issue      = 1'b0;
            end
        endcase
    end

    always_comb begin
        issue_meta.position       = r_idx[POS_W-1:0];
        issue_meta.total_returned = r_empty ? '0 : r_n;
        issue_meta.last           = !r_empty && issue_last;
        issue_meta.empty_res      = r_empty;
    end

    // Memory: write on store, read on issue.
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            mem[r_wr_pos] <= '{tick:           i_in.payload.tick,
                               group_id:       i_in.payload.group_id,
                               thread_id:      i_in.payload.thread_id,
                               thread_flag:    i_in.payload.thread_flag,
                               run_state:      i_in.payload.run_state,
                               cpu_number:     i_in.payload.cpu_number,
                               priority_level: i_in.payload.priority_level};
        end
        if (issue) begin
            r_rdata <= mem[r_addr];
        end
    end

    // Write position wraps; fill count saturates at the ring depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_fill   <= '0;
        end else if (do_store) begin
            r_wr_pos <= (r_wr_pos == ADDR_W'(RING_DEPTH - 1)) ? '0 : r_wr_pos + ADDR_W'(1);
            if (r_fill != FILL_W'(RING_DEPTH)) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
        end
    end

    // Readout counters: load on accept, advance on each issue.
    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_addr  <= rd_start;
            r_idx   <= '0;
            r_n     <= rd_n;
            r_empty <= (rd_n == '0);
        end else if (issue) begin
            r_addr <= (r_addr == ADDR_W'(RING_DEPTH - 1)) ? '0 : r_addr + ADDR_W'(1);
            r_idx  <= r_idx + TOTAL_W'(1);
        end
        if (issue) begin
            r_pmeta <= issue_meta;
        end
    end

    // Build the result word; an empty readout drops the record fields to zero.
    always_comb begin
        push_res = '0;
        if (!r_pmeta.empty_res) begin
            push_res.out_tick           = r_rdata.tick;
            push_res.out_group_id       = r_rdata.group_id;
            push_res.out_thread_id      = r_rdata.thread_id;
            push_res.out_thread_flag    = r_rdata.thread_flag;
            push_res.out_run_state      = r_rdata.run_state;
            push_res.out_cpu_number     = r_rdata.cpu_number;
            push_res.out_priority_level = r_rdata.priority_level;
        end
        push_res.position       = r_pmeta.position;
        push_res.total_returned = r_pmeta.total_returned;
        push_res.last           = r_pmeta.last;
        push_res.empty_res      = r_pmeta.empty_res;
    end

    // Output queue: pop shifts slot 1 forward, push fills the next free slot.
    always_comb begin
        n_q    = r_q;
        n_qcnt = r_qcnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_qcnt = n_qcnt - 2'd1;
        end
        if (r_pend) begin
            n_q[n_qcnt[0]] = push_res;
            n_qcnt         = n_qcnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= '0;
        end else begin
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_out.valid   = (r_qcnt != 2'd0);
    assign o_out.payload = r_q[0];

endmodule
